@@ rtl/core/lavm_pkg.sv @@
// Shared types and constants of the look-at view matrix unit.
`timescale 1ns / 1ps

package lavm_pkg;

   // One output component or position word
   typedef logic signed [31:0] comp_type;
   // Sign-extended vector component fed to a normalizer
   typedef logic signed [63:0] wide_type;

   // Object height after reset, 40.0 in Q16.16
   localparam logic [30:0] HEIGHT_RESET = 31'd2621440;

   // 1.0 in Q2.30
   localparam comp_type UNIT_ONE = 32'sh4000_0000;

   // Fraction bits of unit components; also the rounding shift of translations
   localparam int UNIT_FRAC = 30;

endpackage

@@ rtl/core/lavm_unit.sv @@
// Pipelined vector normalizer: Q2.30 unit vector from an integer vector.
`timescale 1ns / 1ps

module lavm_unit #(
   parameter int SIDE_W = 96
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  lavm_pkg::wide_type   in_vec [3],
   input  logic [SIDE_W-1:0]    in_side,
   output logic                 out_valid,
   output lavm_pkg::comp_type   out_vec [3],
   output logic [SIDE_W-1:0]    out_side
);

   localparam int SQ_STEPS  = 32;
   localparam int DIV_STEPS = 32;
   localparam int LAT       = 6 + SQ_STEPS + 1 + DIV_STEPS + 1;

   // Position of the highest set bit
   function automatic logic [5:0] lead_one(input logic [61:0] m);
      logic [5:0] pos;
      pos = '0;
      for (int i = 0; i < 62; i++) begin
         if (m[i]) pos = 6'(i);
      end
      return pos;
   endfunction

   // valid and side data travel in parallel with the arithmetic
   logic              vld_ff  [LAT];
   logic [SIDE_W-1:0] side_ff [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) vld_ff[i] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
         for (int i = 1; i < LAT; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int i = 1; i < LAT; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   assign out_valid = vld_ff[LAT-1];
   assign out_side  = side_ff[LAT-1];

   // Stage A: sign and magnitude
   logic [61:0] a_mag_ff [3];
   logic [2:0]  a_neg_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            a_neg_ff[i] <= in_vec[i][63];
            a_mag_ff[i] <= in_vec[i][63] ? 62'(-in_vec[i]) : in_vec[i][61:0];
         end
      end
   end

   // Stage B: largest magnitude
   logic [61:0] b_mag_ff [3];
   logic [2:0]  b_neg_ff;
   logic [61:0] b_max_ff;
   logic [61:0] max01;

   assign max01 = (a_mag_ff[0] > a_mag_ff[1]) ? a_mag_ff[0] : a_mag_ff[1];

   always_ff @(posedge clock) begin
      if (en) begin
         b_mag_ff <= a_mag_ff;
         b_neg_ff <= a_neg_ff;
         b_max_ff <= (max01 > a_mag_ff[2]) ? max01 : a_mag_ff[2];
      end
   end

   // Stage C: leading one of the largest magnitude
   logic [61:0] c_mag_ff [3];
   logic [2:0]  c_neg_ff;
   logic [5:0]  c_pos_ff;
   logic        c_zero_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c_mag_ff  <= b_mag_ff;
         c_neg_ff  <= b_neg_ff;
         c_pos_ff  <= lead_one(b_max_ff);
         c_zero_ff <= (b_max_ff == '0);
      end
   end

   // Stage D: shift all magnitudes so the largest lands in [2^30, 2^31)
   logic [30:0] d_mag_ff [3];
   logic [2:0]  d_neg_ff;
   logic        d_zero_ff;
   logic [61:0] d_shift [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (c_pos_ff >= 6'd31) d_shift[i] = c_mag_ff[i] >> (c_pos_ff - 6'd30);
         else                   d_shift[i] = c_mag_ff[i] << (6'd30 - c_pos_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) d_mag_ff[i] <= d_shift[i][30:0];
         d_neg_ff  <= c_neg_ff;
         d_zero_ff <= c_zero_ff;
      end
   end

   // Stage E: squares
   logic [61:0] e_sq_ff  [3];
   logic [30:0] e_mag_ff [3];
   logic [2:0]  e_neg_ff;
   logic        e_zero_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) e_sq_ff[i] <= 62'(d_mag_ff[i]) * 62'(d_mag_ff[i]);
         e_mag_ff  <= d_mag_ff;
         e_neg_ff  <= d_neg_ff;
         e_zero_ff <= d_zero_ff;
      end
   end

   // Stage F and square root steps, two radicand bits per stage
   logic [63:0] sq_rad_ff  [SQ_STEPS+1];
   logic [33:0] sq_rem_ff  [SQ_STEPS+1];
   logic [31:0] sq_root_ff [SQ_STEPS+1];
   logic [30:0] sq_mag_ff  [SQ_STEPS+1][3];
   logic [2:0]  sq_neg_ff  [SQ_STEPS+1];
   logic        sq_zero_ff [SQ_STEPS+1];

   always_ff @(posedge clock) begin
      if (en) begin
         sq_rad_ff[0]  <= 64'(e_sq_ff[0]) + 64'(e_sq_ff[1]) + 64'(e_sq_ff[2]);
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_mag_ff[0]  <= e_mag_ff;
         sq_neg_ff[0]  <= e_neg_ff;
         sq_zero_ff[0] <= e_zero_ff;
      end
   end

   for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
      logic [34:0] rem_sh;
      logic [34:0] trial;
      logic        take;

      assign rem_sh = {sq_rem_ff[k][32:0], sq_rad_ff[k][63-2*k -: 2]};
      assign trial  = {1'b0, sq_root_ff[k], 2'b01};
      assign take   = (rem_sh >= trial);

      always_ff @(posedge clock) begin
         if (en) begin
            sq_rem_ff[k+1]  <= take ? 34'(rem_sh - trial) : rem_sh[33:0];
            sq_root_ff[k+1] <= {sq_root_ff[k][30:0], take};
            sq_rad_ff[k+1]  <= sq_rad_ff[k];
            sq_mag_ff[k+1]  <= sq_mag_ff[k];
            sq_neg_ff[k+1]  <= sq_neg_ff[k];
            sq_zero_ff[k+1] <= sq_zero_ff[k];
         end
      end
   end

   // Stage G: rounded dividends, then one quotient bit per stage
   logic [31:0] dv_rem_ff  [DIV_STEPS+1][3];
   logic [31:0] dv_low_ff  [DIV_STEPS+1][3];
   logic [31:0] dv_quo_ff  [DIV_STEPS+1][3];
   logic [31:0] dv_den_ff  [DIV_STEPS+1];
   logic [2:0]  dv_neg_ff  [DIV_STEPS+1];
   logic        dv_zero_ff [DIV_STEPS+1];
   logic [61:0] g_num [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         g_num[i] = 62'({sq_mag_ff[SQ_STEPS][i], 30'd0})
                  + 62'(sq_root_ff[SQ_STEPS][31:1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[0][i] <= 32'(g_num[i][61:32]);
            dv_low_ff[0][i] <= g_num[i][31:0];
            dv_quo_ff[0][i] <= '0;
         end
         dv_den_ff[0]  <= sq_root_ff[SQ_STEPS];
         dv_neg_ff[0]  <= sq_neg_ff[SQ_STEPS];
         dv_zero_ff[0] <= sq_zero_ff[SQ_STEPS];
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [32:0] rs   [3];
      logic        ge   [3];
      logic [32:0] diff [3];

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            rs[i]   = {dv_rem_ff[k][i], dv_low_ff[k][i][31-k]};
            diff[i] = rs[i] - {1'b0, dv_den_ff[k]};
            ge[i]   = (rs[i] >= {1'b0, dv_den_ff[k]});
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               dv_rem_ff[k+1][i] <= ge[i] ? diff[i][31:0] : rs[i][31:0];
               dv_quo_ff[k+1][i] <= {dv_quo_ff[k][i][30:0], ge[i]};
            end
            dv_low_ff[k+1]  <= dv_low_ff[k];
            dv_den_ff[k+1]  <= dv_den_ff[k];
            dv_neg_ff[k+1]  <= dv_neg_ff[k];
            dv_zero_ff[k+1] <= dv_zero_ff[k];
         end
      end
   end

   // Stage H: restore signs; a zero vector stays zero
   lavm_pkg::comp_type h_vec_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            if (dv_zero_ff[DIV_STEPS])     h_vec_ff[i] <= '0;
            else if (dv_neg_ff[DIV_STEPS][i]) h_vec_ff[i] <= -dv_quo_ff[DIV_STEPS][i];
            else                           h_vec_ff[i] <= dv_quo_ff[DIV_STEPS][i];
         end
      end
   end

   assign out_vec = h_vec_ff;

endmodule

@@ rtl/core/look_at_view_matrix.sv @@
// Top level of the look-at view matrix unit.
`timescale 1ns / 1ps
//
// Usage: each req item carries an eye position and an object base position
// (signed Q16.16). The target is the base raised in z by half of the object
// height held in the csr register. One rsp item returns the three upper rows
// of the view matrix: side, up and forward unit vectors in Q2.30, each with
// its negated dot product with the eye as a saturated Q16.16 translation.
// The csr channel is always ready; write it only while no item is in flight.
// The path holds three chained normalizers of 72 stages each (a 32-step
// square root and a 32-step divider per normalizer) plus the input
// difference, the cross product and the translation stages.
// Throughput is one item per cycle. The whole pipeline advances as one:
// when rsp_tvalid is high and rsp_tready low, all stages and req_tready hold,
// and no item is lost or repeated.
// Synchronous reset clears all valid bits and loads the object height with
// 40.0; the pipeline is ready in the cycle after reset.

module look_at_view_matrix (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // eye_x, eye_y, eye_z, target_x, target_y, target_z (32 bits each)
   input  logic [191:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // side_x, side_y, side_z, side_shift, upv_x, upv_y, upv_z, upv_shift,
   // fwd_x, fwd_y, fwd_z, fwd_shift (32 bits each)
   output logic [383:0]  rsp_tdata,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [30:0]   csr_data
);

   logic en;
   assign en = !rsp_tvalid | rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   // Object height register
   logic [30:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         height_ff <= lavm_pkg::HEIGHT_RESET;
      end else if (csr_valid) begin
         height_ff <= csr_data;
      end
   end

   // Stage 0: eye minus raised target
   lavm_pkg::comp_type eye   [3];
   lavm_pkg::comp_type tgt   [3];
   logic signed [33:0] half_h;
   logic               s0_vld_ff;
   lavm_pkg::comp_type s0_eye_ff [3];
   logic signed [33:0] s0_d_ff   [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         eye[i] = req_tdata[32*i +: 32];
         tgt[i] = req_tdata[96+32*i +: 32];
      end
   end
   assign half_h = {4'd0, height_ff[30:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (en) begin
         s0_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_eye_ff  <= eye;
         s0_d_ff[0] <= 34'(eye[0]) - 34'(tgt[0]);
         s0_d_ff[1] <= 34'(eye[1]) - 34'(tgt[1]);
         s0_d_ff[2] <= 34'(eye[2]) - 34'(tgt[2]) - half_h;
      end
   end

   // Forward vector
   lavm_pkg::wide_type f_in [3];
   logic               f_vld;
   lavm_pkg::comp_type f_vec [3];
   logic [95:0]        f_side;

   always_comb begin
      for (int i = 0; i < 3; i++) f_in[i] = 64'(s0_d_ff[i]);
   end

   lavm_unit #(.SIDE_W(96)) u_fwd (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s0_vld_ff),
      .in_vec    (f_in),
      .in_side   ({s0_eye_ff[2], s0_eye_ff[1], s0_eye_ff[0]}),
      .out_valid (f_vld),
      .out_vec   (f_vec),
      .out_side  (f_side)
   );

   // Side vector: (0,0,1) x f = (-f_y, f_x, 0)
   lavm_pkg::wide_type sv_in [3];
   logic               sd_vld;
   lavm_pkg::comp_type sd_vec [3];
   logic [191:0]       sd_side;

   assign sv_in[0] = -64'(f_vec[1]);
   assign sv_in[1] = 64'(f_vec[0]);
   assign sv_in[2] = '0;

   lavm_unit #(.SIDE_W(192)) u_side (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_vld),
      .in_vec    (sv_in),
      .in_side   ({f_vec[2], f_vec[1], f_vec[0], f_side}),
      .out_valid (sd_vld),
      .out_vec   (sd_vec),
      .out_side  (sd_side)
   );

   // Cross product f x s; the side vector has no z part
   lavm_pkg::comp_type xf [3];
   logic               x1_vld_ff;
   logic [287:0]       x1_side_ff;
   lavm_pkg::wide_type x1_p_ff [4];
   logic               x2_vld_ff;
   logic [287:0]       x2_side_ff;
   lavm_pkg::wide_type x2_uv_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) xf[i] = sd_side[96+32*i +: 32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_vld_ff <= 1'b0;
         x2_vld_ff <= 1'b0;
      end else if (en) begin
         x1_vld_ff <= sd_vld;
         x2_vld_ff <= x1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_side_ff <= {sd_vec[2], sd_vec[1], sd_vec[0], sd_side};
         x1_p_ff[0] <= 64'(xf[2]) * 64'(sd_vec[1]);
         x1_p_ff[1] <= 64'(xf[2]) * 64'(sd_vec[0]);
         x1_p_ff[2] <= 64'(xf[0]) * 64'(sd_vec[1]);
         x1_p_ff[3] <= 64'(xf[1]) * 64'(sd_vec[0]);
         x2_side_ff  <= x1_side_ff;
         x2_uv_ff[0] <= -x1_p_ff[0];
         x2_uv_ff[1] <= x1_p_ff[1];
         x2_uv_ff[2] <= x1_p_ff[2] - x1_p_ff[3];
      end
   end

   // Recomputed up vector
   logic               up_vld;
   lavm_pkg::comp_type up_vec [3];
   logic [287:0]       up_side;

   lavm_unit #(.SIDE_W(288)) u_up (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (x2_vld_ff),
      .in_vec    (x2_uv_ff),
      .in_side   (x2_side_ff),
      .out_valid (up_vld),
      .out_vec   (up_vec),
      .out_side  (up_side)
   );

   // Translation: dot products, negate, round, saturate
   lavm_pkg::comp_type row_c [3][3];
   lavm_pkg::comp_type eye_c [3];
   logic               d1_vld_ff, d2_vld_ff, d3_vld_ff;
   lavm_pkg::comp_type d1_row_ff [3][3];
   lavm_pkg::comp_type d2_row_ff [3][3];
   lavm_pkg::comp_type d3_row_ff [3][3];
   lavm_pkg::wide_type d1_p_ff [3][3];
   logic signed [65:0] d2_t_ff [3];
   logic [65:0]        d3_mag_ff [3];
   logic [2:0]         d3_neg_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         eye_c[i]    = up_side[32*i +: 32];
         row_c[0][i] = up_side[192+32*i +: 32];
         row_c[1][i] = up_vec[i];
         row_c[2][i] = up_side[96+32*i +: 32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_vld_ff <= 1'b0;
         d2_vld_ff <= 1'b0;
         d3_vld_ff <= 1'b0;
      end else if (en) begin
         d1_vld_ff <= up_vld;
         d2_vld_ff <= d1_vld_ff;
         d3_vld_ff <= d2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_row_ff <= row_c;
         d2_row_ff <= d1_row_ff;
         d3_row_ff <= d2_row_ff;
         for (int r = 0; r < 3; r++) begin
            for (int i = 0; i < 3; i++) begin
               d1_p_ff[r][i] <= 64'(row_c[r][i]) * 64'(eye_c[i]);
            end
            d2_t_ff[r] <= -(66'(d1_p_ff[r][0]) + 66'(d1_p_ff[r][1])
                            + 66'(d1_p_ff[r][2]));
            d3_neg_ff[r] <= d2_t_ff[r][65];
            d3_mag_ff[r] <= d2_t_ff[r][65] ? 66'(-d2_t_ff[r]) : d2_t_ff[r];
         end
      end
   end

   // Output register
   logic               rsp_vld_ff;
   lavm_pkg::comp_type rsp_fld_ff [12];
   logic [65:0]        rnd [3];
   logic [35:0]        rmag [3];
   lavm_pkg::comp_type shift_c [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         rnd[r]  = d3_mag_ff[r] + (66'd1 << (lavm_pkg::UNIT_FRAC - 1));
         rmag[r] = rnd[r][65:30];
         if (d3_neg_ff[r]) begin
            shift_c[r] = (rmag[r] > 36'h0_8000_0000) ? 32'sh8000_0000 : 32'(-rmag[r]);
         end else begin
            shift_c[r] = (rmag[r] > 36'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : rmag[r][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         rsp_vld_ff <= d3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            for (int i = 0; i < 3; i++) rsp_fld_ff[4*r+i] <= d3_row_ff[r][i];
            rsp_fld_ff[4*r+3] <= shift_c[r];
         end
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   always_comb begin
      for (int i = 0; i < 12; i++) rsp_tdata[32*i +: 32] = rsp_fld_ff[i];
   end

   // The side vector never has a z component
   a_side_z_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_fld_ff[2] == '0)
      else $error("side_z nonzero");

   // The forward x component never exceeds 1.0 in magnitude
   a_fwd_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_fld_ff[8] <= lavm_pkg::UNIT_ONE
                      && rsp_fld_ff[8] >= -lavm_pkg::UNIT_ONE))
      else $error("fwd_x out of unit range");

   // A zero forward vector forces zero side x and y components
   a_zero_chain: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_fld_ff[8] == '0 && rsp_fld_ff[9] == '0
       && rsp_fld_ff[10] == '0) |-> (rsp_fld_ff[0] == '0 && rsp_fld_ff[1] == '0))
      else $error("side row nonzero with zero forward");

   // After reset no result is presented
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

@@ tb/sv/lavm_checker.sv @@
// Checker for the look-at view matrix unit: predicts each result and compares it.
`timescale 1ns / 1ps

module lavm_checker (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [191:0]  req_tdata,
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [383:0]  rsp_tdata,
   input  logic          csr_valid,
   input  logic          csr_ready,
   input  logic [30:0]   csr_data,
   output int            fail_count,
   output int            pending
);

   logic [30:0]  height_q;
   logic [383:0] matrix_q[$];

   // Integer square root of a 64-bit value
   function automatic logic [63:0] isqrt(input logic [63:0] v);
      logic [63:0] res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= res + bit_w) begin
            v = v - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   // Normalize an integer vector to Q2.30; zero stays zero
   task automatic normalize(input longint v[3], output longint r[3]);
      logic [63:0] mag[3];
      logic [63:0] m, sum, n, q;
      bit neg[3];
      m = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i] < 0;
         mag[i] = neg[i] ? 64'(-v[i]) : 64'(v[i]);
         if (mag[i] > m) m = mag[i];
      end
      if (m == 0) begin
         r[0] = 0; r[1] = 0; r[2] = 0;
      end else begin
         while (m >= (64'd1 << 31)) begin
            for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
            m = m >> 1;
         end
         while (m < (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
            m = m << 1;
         end
         for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
         n = isqrt(sum);
         for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << lavm_pkg::UNIT_FRAC) + (n >> 1)) / n;
            r[i] = neg[i] ? -longint'(q) : longint'(q);
         end
      end
   endtask

   // Negated row dot eye, rounded to position format and saturated
   function automatic lavm_pkg::comp_type translation(input longint r[3],
                                                      input longint e[3]);
      longint t;
      logic [63:0] mag;
      t = -(r[0] * e[0] + r[1] * e[1] + r[2] * e[2]);
      mag = t < 0 ? 64'(-t) : 64'(t);
      mag = (mag + (64'd1 << (lavm_pkg::UNIT_FRAC - 1))) >> lavm_pkg::UNIT_FRAC;
      if (t < 0) begin
         return mag > 64'h8000_0000 ? 32'sh8000_0000
                                    : lavm_pkg::comp_type'(-longint'(mag));
      end
      return mag > 64'h7FFF_FFFF ? 32'sh7FFF_FFFF : lavm_pkg::comp_type'(mag);
   endfunction

   function automatic logic [127:0] pack_row(input longint r[3], input longint e[3]);
      return {translation(r, e), r[2][31:0], r[1][31:0], r[0][31:0]};
   endfunction

   task automatic predict_matrix(input logic [191:0] d, output logic [383:0] m);
      longint eye[3], dv[3], f[3], sv[3], s[3], uv[3], u[3];
      for (int i = 0; i < 3; i++) begin
         eye[i] = longint'(lavm_pkg::comp_type'(d[32*i +: 32]));
         dv[i] = eye[i] - longint'(lavm_pkg::comp_type'(d[96 + 32*i +: 32]));
      end
      dv[2] = dv[2] - longint'(height_q >> 1);
      normalize(dv, f);
      sv[0] = -f[1]; sv[1] = f[0]; sv[2] = 0;
      normalize(sv, s);
      uv[0] = f[1] * s[2] - f[2] * s[1];
      uv[1] = f[2] * s[0] - f[0] * s[2];
      uv[2] = f[0] * s[1] - f[1] * s[0];
      normalize(uv, u);
      m = {pack_row(f, eye), pack_row(u, eye), pack_row(s, eye)};
   endtask

   task automatic report_mismatch(input string what, input int idx,
                                  input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s field %0d: got %h want %h", what, idx, got, want);
      fail_count++;
   endtask

   initial fail_count = 0;
   assign pending = matrix_q.size();

   always @(posedge clock) begin
      logic [383:0] want;
      if (reset) begin
         height_q <= lavm_pkg::HEIGHT_RESET;
         matrix_q.delete();
      end else begin
         if (csr_valid && csr_ready) height_q <= csr_data;
         if (req_tvalid && req_tready) begin
            predict_matrix(req_tdata, want);
            matrix_q = {matrix_q, want};
         end
         if (rsp_tvalid && rsp_tready) begin
            if (matrix_q.size() == 0) begin
               report_mismatch("unexpected", 0, 0, 0);
            end else begin
               want = matrix_q.pop_front();
               for (int i = 0; i < 12; i++)
                  if (rsp_tdata[32*i +: 32] !== want[32*i +: 32])
                     report_mismatch("matrix", i, rsp_tdata[32*i +: 32], want[32*i +: 32]);
            end
         end
      end
   end
endmodule

@@ tb/sv/testbench.sv @@
// Top of the look-at view matrix testbench: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module testbench;

   localparam int LATENCY = 223;
   localparam int LIMIT = 400000;

   logic          clock = 0;
   logic          reset = 1;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [191:0]  req_tdata = 0;
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [383:0]  rsp_tdata;
   logic          csr_valid = 0;
   logic          csr_ready;
   logic [30:0]   csr_data = 0;
   int            fail_count, pending;
   int            cycle_count = 0;
   int            hold_off = 0;
   bit            stall_busy = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   look_at_view_matrix u_top (.*);

   lavm_checker u_check (.*);

   // Timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   // Receiver: own stall pattern, plus long hold-offs on request; always ready while draining
   always @(posedge clock) begin
      if (hold_off > 0) begin
         rsp_tready <= 0;
         hold_off <= hold_off - 1;
      end else if (stall_busy) begin
         rsp_tready <= 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'(int'($urandom_range(0, 200000)) - 100000);
         3: return 32'(int'($urandom_range(0, 2000)) - 1000) << 16;
         default: return $urandom;
      endcase
   endfunction

   // Offer one item and wait until it is taken
   task automatic send_item(input logic [191:0] d);
      req_tvalid <= 1;
      req_tdata <= d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic idle_sender(input int n);
      req_tvalid <= 0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      stall_busy = 1;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      stall_busy = 0;
   endtask

   task automatic write_height(input logic [30:0] h);
      csr_valid <= 1;
      csr_data <= h;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 0;
   endtask

   function automatic logic [191:0] pack_req(input logic [31:0] ex, ey, ez, tx, ty, tz);
      return {tz, ty, tx, ez, ey, ex};
   endfunction

   task automatic random_phase(input int count);
      logic [31:0] e[3], t[3];
      int burst;
      int sent;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 20);
         repeat (burst) begin
            for (int i = 0; i < 3; i++) begin
               e[i] = rand_pos();
               t[i] = ($urandom_range(0, 7) == 0) ? e[i] : rand_pos();
            end
            // Sometimes point straight along z
            if ($urandom_range(0, 9) == 0) begin
               t[0] = e[0]; t[1] = e[1];
            end
            send_item(pack_req(e[0], e[1], e[2], t[0], t[1], t[2]));
            sent++;
         end
         if ($urandom_range(0, 2) == 0) idle_sender($urandom_range(1, 15));
      end
   endtask

   initial begin
      logic [31:0] h;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes, degenerate vectors, reset height
      send_item(pack_req(0, 0, 0, 0, 0, 0));
      send_item(pack_req(0, 0, 32'd1310720, 0, 0, 0));        // eye on raised target
      send_item(pack_req(5 << 16, 7 << 16, 9 << 16, 5 << 16, 7 << 16, 0)); // along z
      send_item(pack_req(10 << 16, 0, 0, 0, 0, 0));
      send_item(pack_req(0, 10 << 16, 0, 0, 0, 0));
      send_item(pack_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                         32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
      send_item(pack_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
      send_item(pack_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0));
      send_item(pack_req(1, 0, 0, 0, 0, 32'hFFEC_0000));
      send_item(pack_req(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0));
      drain();

      // Extremes of the height
      write_height(31'd0);
      send_item(pack_req(0, 0, 0, 0, 0, 0));
      send_item(pack_req(3 << 16, 4 << 16, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000));
      random_phase(60);
      drain();
      write_height(31'h7FFF_FFFF);
      send_item(pack_req(0, 0, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000));
      send_item(pack_req(0, 0, 32'h3FFF_FFFF, 0, 0, 0));
      random_phase(60);
      drain();

      // Long receiver hold-off while items keep coming
      write_height(lavm_pkg::HEIGHT_RESET);
      hold_off = 600;
      random_phase(400);
      drain();

      // Random heights over the rest
      for (int p = 0; p < 4; p++) begin
         h = $urandom;
         write_height(h[30:0]);
         random_phase(70);
         drain();
      end

      if (fail_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end
endmodule
